### rtl/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types, command codes and the backoff delay table of the retry
// scheduler.
// ----------------------------------------------------------------------------
package brs_pkg;

	localparam int StepW     = 3;
	localparam int DelayMsW  = 24;
	localparam int DelaySecW = 14;
	localparam int TickW     = 32;
	localparam int RateW     = 14;
	localparam int TableLen  = 7;

	localparam logic [RateW-1:0]    RATE_RESET   = 14'd1000;
	localparam logic [DelayMsW-1:0] MAX_DELAY_MS = 24'd14400000;
	localparam logic [DelaySecW-1:0] MAX_DELAY_S = 14'd14400;

	typedef enum logic [1:0] {
		FUNC_RESET    = 2'd0,
		FUNC_SCHEDULE = 2'd1,
		FUNC_CANCEL   = 2'd2,
		FUNC_TAKE_DUE = 2'd3
	} func_t;

	typedef struct packed {
		logic [StepW-1:0]    step;
		logic                pending;
		logic [DelayMsW-1:0] hold_ms;
		logic [TickW-1:0]    deadline;
	} sched_state_t;

	// Every table entry is a whole number of seconds, so the ms-to-tick
	// conversion reduces to seconds times the tick rate with no division.
	localparam logic [DelayMsW-1:0] DELAY_MS_TABLE [TableLen] = '{
		24'd30000, 24'd60000, 24'd120000, 24'd300000,
		24'd3600000, 24'd7200000, 24'd14400000
	};
	localparam logic [DelaySecW-1:0] DELAY_SEC_TABLE [TableLen] = '{
		14'd30, 14'd60, 14'd120, 14'd300, 14'd3600, 14'd7200, 14'd14400
	};

	function automatic logic [DelayMsW-1:0] table_ms(input logic [StepW-1:0] idx,
			input logic [StepW:0] step_count);
		logic [DelayMsW-1:0] d;
		d = MAX_DELAY_MS;
		if ({1'b0, idx} < step_count && idx < StepW'(TableLen))
			d = DELAY_MS_TABLE[idx];
		return d;
	endfunction

	function automatic logic [DelaySecW-1:0] delay_sec(input logic [StepW-1:0] idx,
			input logic [StepW:0] step_count);
		logic [DelaySecW-1:0] d;
		d = MAX_DELAY_S;
		if ({1'b0, idx} < step_count && idx < StepW'(TableLen))
			d = DELAY_SEC_TABLE[idx];
		return d;
	endfunction

endpackage

### rtl/brs_next.sv
// ----------------------------------------------------------------------------
// brs_next
// Next-state logic of the retry scheduler for one command.
// ----------------------------------------------------------------------------
module brs_next #(
	parameter int STEP_COUNT = 7
) (
	input  brs_pkg::func_t                 func,
	input  logic [brs_pkg::TickW-1:0]      now_cnt,
	input  logic [brs_pkg::RateW-1:0]      tick_rate_hz,
	input  brs_pkg::sched_state_t          cur,
	output brs_pkg::sched_state_t          nxt,
	output logic                           due
);

	localparam logic [brs_pkg::StepW:0] StepCnt = (brs_pkg::StepW+1)'(STEP_COUNT);

	logic [brs_pkg::DelaySecW-1:0]                delay_s;
	logic [brs_pkg::DelaySecW+brs_pkg::RateW-1:0] delay_ticks;
	logic [brs_pkg::TickW-1:0]                    since_deadline;
	logic [brs_pkg::StepW:0]                      step_inc;

	assign delay_s        = brs_pkg::delay_sec(cur.step, StepCnt);
	assign delay_ticks    = delay_s * tick_rate_hz;
	assign since_deadline = now_cnt - cur.deadline;
	assign step_inc       = {1'b0, cur.step} + 1'b1;

	always_comb begin
		nxt = cur;
		due = 1'b0;
		case (func)
			brs_pkg::FUNC_RESET: begin
				nxt = '0;
			end
			brs_pkg::FUNC_SCHEDULE: begin
				nxt.hold_ms  = brs_pkg::table_ms(cur.step, StepCnt);
				nxt.deadline = now_cnt + brs_pkg::TickW'(delay_ticks);
				nxt.pending  = 1'b1;
				if (step_inc < StepCnt)
					nxt.step = step_inc[brs_pkg::StepW-1:0];
			end
			brs_pkg::FUNC_CANCEL: begin
				nxt.pending  = 1'b0;
				nxt.hold_ms  = '0;
				nxt.deadline = '0;
			end
			brs_pkg::FUNC_TAKE_DUE: begin
				// Wrap-safe: due once now is at or past the deadline by less than half the tick range.
				if (cur.pending && !since_deadline[brs_pkg::TickW-1]) begin
					nxt.pending  = 1'b0;
					nxt.hold_ms  = '0;
					nxt.deadline = '0;
					due          = 1'b1;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

### rtl/backoff_retry_scheduler_core.sv
// ----------------------------------------------------------------------------
// backoff_retry_scheduler_core
// Table-driven backoff retry scheduler: one command beat in, one status beat out.
// ----------------------------------------------------------------------------
// An accepted command beat is held in the input register; the combinational
// state update feeds the result register. Each register holds one beat.
// Throughput: one command per cycle unless m_tready stalls the result beat.
// Reset: arst_n clears the scheduler state and both registers' valid flags
//   and loads the tick rate with 1000.
module backoff_retry_scheduler_core #(
	parameter int STEP_COUNT = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [13:0] cfg_data,      // tick_rate_hz
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,       // now[31:0]
	input  logic [1:0]  s_tuser,       // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// due[0], retry_pending[1], delay_in_use_ms[25:2], deadline_ticks[57:26],
	// step_after[60:58], zero fill [63:61]
	output logic [63:0] m_tdata
);

	logic [brs_pkg::RateW-1:0] tick_rate_q;
	logic                      valid_s1;
	brs_pkg::func_t            func_s1;
	logic [brs_pkg::TickW-1:0] now_s1;
	logic                      fire_s1;
	brs_pkg::sched_state_t     state_q;
	brs_pkg::sched_state_t     state_nxt;
	logic                      due_nxt;
	logic                      out_valid_q;
	logic                      due_q;
	brs_pkg::sched_state_t     out_state_q;

	assign cfg_ready = 1'b1;
	assign fire_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= brs_pkg::RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tick_rate_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= brs_pkg::func_t'(s_tuser);
			now_s1  <= s_tdata;
		end
	end

	brs_next #(
		.STEP_COUNT(STEP_COUNT)
	) u_next (
		.func        (func_s1),
		.now_cnt     (now_s1),
		.tick_rate_hz(tick_rate_q),
		.cur         (state_q),
		.nxt         (state_nxt),
		.due         (due_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			due_q       <= due_nxt;
			out_state_q <= state_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_state_q.step, out_state_q.deadline,
		out_state_q.hold_ms, out_state_q.pending, due_q};

endmodule

### rtl/brs_checker.sv
// ----------------------------------------------------------------------------
// brs_checker
// Port-level checks of the retry scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module brs_checker #(
	parameter int STEP_COUNT = 7
) (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_ready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	// A stalled result beat must not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// A retry that is taken leaves nothing pending behind it.
	a_due_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |->
			!m_tdata[1] && m_tdata[25:2] == 24'd0 && m_tdata[57:26] == 32'd0)
		else $error("due reported with retry still held");

	// Without a pending retry the delay and deadline read as zero.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[25:2] == 24'd0 && m_tdata[57:26] == 32'd0)
		else $error("stale delay or deadline without pending retry");

	// A pending retry always has a nonzero delay and the step stays below STEP_COUNT.
	a_pending_delay: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[1] || m_tdata[25:2] != 24'd0)
			&& {1'b0, m_tdata[60:58]} < 4'(STEP_COUNT))
		else $error("bad delay or step index");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration channel stalled");

endmodule

bind backoff_retry_scheduler_core brs_checker #(
	.STEP_COUNT(STEP_COUNT)
) u_brs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_ready(cfg_ready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
